// ===== src/sbcp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbcp_pkg
// Shared types and constants of the six-bit character set bit packer.
// ----------------------------------------------------------------------------
package sbcp_pkg;

    // Width of the longest bit string that one item appends.
    localparam int unsigned BitsW   = 19;
    // Most bytes that one item can release.
    localparam int unsigned MaxOut  = 3;

    // Character codes used by the classifier.
    localparam logic [7:0] ChrTab    = 8'd9;
    localparam logic [7:0] ChrCr     = 8'd15;
    localparam logic [7:0] ChrEsc    = 8'd27;
    localparam logic [7:0] ChrSpace  = 8'd32;
    localparam logic [7:0] ChrOpen   = 8'd40;
    localparam logic [7:0] ChrAt     = 8'd64;
    localparam logic [7:0] ChrUpperA = 8'd65;
    localparam logic [7:0] ChrUpperZ = 8'd90;
    localparam logic [7:0] ChrClose  = 8'd93;
    localparam logic [7:0] ChrLowerA = 8'd97;
    localparam logic [7:0] ChrLowerZ = 8'd122;
    localparam logic [7:0] ChrDel    = 8'd127;

    // Codes sent on the wire.
    localparam logic [5:0] CodeEscape  = 6'd32;
    localparam logic [6:0] CodeShift   = 7'd27;
    localparam logic [6:0] CodeEnd     = 7'd48;
    localparam logic [5:0] CodeEscChr  = 6'd62;
    localparam logic [5:0] CodeDelChr  = 6'd63;

    // Bit lengths of the three string shapes.
    localparam logic [4:0] LenCode  = 5'd6;
    localparam logic [4:0] LenEsc   = 5'd13;
    localparam logic [4:0] LenShift = 5'd19;

    // Encoder result: left-justified bits, their count and the next case mode.
    typedef struct packed {
        logic [BitsW-1:0] bits;
        logic [4:0]       len;
        logic             mode_next;
    } sbcp_enc_t;

    // Bytes released by one item.
    typedef struct packed {
        logic [MaxOut-1:0][7:0] bytes;
        logic [1:0]             count;
        logic                   padded;
    } sbcp_bundle_t;

endpackage

// ===== src/sbcp_encoder.sv =====
// ----------------------------------------------------------------------------
// sbcp_encoder
// Classifies one input byte and forms the left-justified bit string it sends.
// ----------------------------------------------------------------------------
module sbcp_encoder (
    input  logic              [7:0] in_byte,
    input  logic                    end_of_stream,
    input  logic                    mode,
    output sbcp_pkg::sbcp_enc_t     enc
);
    import sbcp_pkg::*;

    logic       is_upper;
    logic       is_lower;
    logic       in_main;
    logic       in_ctrl;
    logic       in_set;
    logic       need_shift;
    logic [7:0] folded;
    logic [7:0] diff32;
    logic [7:0] diff8;
    logic [5:0] code;

    // Character classes.
    always_comb
    begin
        is_upper = (in_byte >= ChrUpperA) && (in_byte <= ChrUpperZ);
        is_lower = (in_byte >= ChrLowerA) && (in_byte <= ChrLowerZ);
        in_main  = (in_byte >= ChrOpen) && (in_byte <= ChrClose) && (in_byte != ChrAt);
        in_ctrl  = (in_byte >= ChrTab) && (in_byte <= ChrCr);
        in_set   = in_main || in_ctrl || is_lower || (in_byte == ChrSpace)
                   || (in_byte == ChrEsc) || (in_byte == ChrDel);
        need_shift = (is_upper && mode) || (is_lower && !mode);
    end

    // Six-bit code of an in-set byte; lower case letters fold to upper case.
    always_comb
    begin
        folded = is_lower ? (in_byte - ChrSpace) : in_byte;
        diff32 = folded - ChrSpace;
        diff8  = in_byte - 8'd8;
        if (is_lower || in_main)
        begin
            code = diff32[5:0];
        end
        else if (in_byte == ChrSpace)
        begin
            code = 6'd0;
        end
        else if (in_ctrl)
        begin
            code = diff8[5:0];
        end
        else if (in_byte == ChrEsc)
        begin
            code = CodeEscChr;
        end
        else
        begin
            code = CodeDelChr;
        end
    end

    // Bit string and case mode update.
    always_comb
    begin
        enc.mode_next = mode;
        if (end_of_stream)
        begin
            enc.bits = {CodeEscape, CodeEnd, 6'd0};
            enc.len  = LenEsc;
        end
        else if (!in_set)
        begin
            enc.bits = {CodeEscape, in_byte[6:0], 6'd0};
            enc.len  = LenEsc;
        end
        else if (need_shift)
        begin
            enc.bits      = {CodeEscape, CodeShift, code};
            enc.len       = LenShift;
            enc.mode_next = is_lower;
        end
        else
        begin
            enc.bits = {code, 13'd0};
            enc.len  = LenCode;
        end
    end

endmodule

// ===== src/sbcp_packer.sv =====
// ----------------------------------------------------------------------------
// sbcp_packer
// Merges the pending partial byte with new bits and splits off whole bytes.
// ----------------------------------------------------------------------------
module sbcp_packer (
    input  sbcp_pkg::sbcp_enc_t     enc,
    input  logic                    end_of_stream,
    input  logic              [7:0] pend_bits,
    input  logic              [2:0] pend_cnt,
    output sbcp_pkg::sbcp_bundle_t  bundle,
    output logic              [7:0] pend_bits_next,
    output logic              [2:0] pend_cnt_next
);
    import sbcp_pkg::*;

    logic [31:0] window;
    logic [4:0]  total;
    logic [1:0]  whole;
    logic [7:0]  rest;

    // The new bits land right after the pending ones, most significant first.
    always_comb
    begin
        window = {pend_bits, 24'd0} | ({enc.bits, 13'd0} >> pend_cnt);
        total  = {2'd0, pend_cnt} + enc.len;
        whole  = total[4:3];
        case (whole)
            2'd0:    rest = window[31:24];
            2'd1:    rest = window[23:16];
            2'd2:    rest = window[15:8];
            default: rest = window[7:0];
        endcase
    end

    // Bytes released; an end item also flushes a partial byte as padded.
    always_comb
    begin
        bundle.bytes  = {window[15:8], window[23:16], window[31:24]};
        bundle.count  = whole;
        bundle.padded = 1'b0;
        pend_bits_next = rest;
        pend_cnt_next  = total[2:0];
        if (end_of_stream)
        begin
            pend_bits_next = 8'd0;
            pend_cnt_next  = 3'd0;
            if (total[2:0] != 3'd0)
            begin
                bundle.padded = 1'b1;
                bundle.count  = whole + 2'd1;
            end
        end
    end

endmodule

// ===== src/sbcp_out_buffer.sv =====
// ----------------------------------------------------------------------------
// sbcp_out_buffer
// Holds the bytes of one item and hands them out one per accepted result.
// ----------------------------------------------------------------------------
module sbcp_out_buffer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  sbcp_pkg::sbcp_bundle_t  bundle,
    output logic                    free,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic              [7:0] out_byte,
    output logic                    last_of_run,
    output logic                    padded_final
);
    import sbcp_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    logic [1:0]   idx_reg;
    logic [1:0]   idx_next;
    sbcp_bundle_t bund_reg;
    sbcp_bundle_t bund_next;
    logic         is_last;

    // Result side.
    always_comb
    begin
        is_last      = (idx_reg == (bund_reg.count - 2'd1));
        out_valid    = valid_reg;
        out_byte     = bund_reg.bytes[idx_reg];
        last_of_run  = is_last;
        padded_final = bund_reg.padded && is_last;
        free         = !valid_reg || (out_ready && is_last);
    end

    // Step through the held bytes; take a new item once the last one leaves.
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        bund_next  = bund_reg;
        if (valid_reg && out_ready && !is_last)
        begin
            idx_next = idx_reg + 2'd1;
        end
        if (free)
        begin
            valid_next = load && (bundle.count != 2'd0);
            idx_next   = 2'd0;
            bund_next  = bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bund_reg <= bund_next;
    end

    // The byte index never runs past the bytes held.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < bund_reg.count))
        else $error("byte index beyond held bytes");

    // A held item always carries at least one byte.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (bund_reg.count != 2'd0))
        else $error("empty item held for output");

endmodule

// ===== src/six_bit_charset_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// six_bit_charset_bit_packer_unit
// Packs bytes into a six-bit character set bit stream, most significant first.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | in_byte, end_of_stream
//  result   | out_valid / out_ready| out_byte, last_of_run, padded_final
//
// An item is encoded and packed straight from the input register, so its
// first byte shows from the result register once the item moves on. An
// item that releases k bytes (one to three) holds the result register until
// its last byte is accepted, so the rate is one item per cycle for items
// that release at most one byte while the result port does not stall; the
// single result port sets that figure. Reset clears the case mode, the
// partial byte and all valid flags. A stalled result port holds the result
// register, and the input register fills behind it before in_ready drops.
// ----------------------------------------------------------------------------
module six_bit_charset_bit_packer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       padded_final
);
    import sbcp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         eos_reg;
    logic         mode_reg;
    logic [7:0]   pend_bits_reg;
    logic [2:0]   pend_cnt_reg;
    logic [7:0]   pend_bits_next;
    logic [2:0]   pend_cnt_next;
    logic         buf_free;
    logic         advance;
    sbcp_enc_t    enc;
    sbcp_bundle_t bundle;

    // The item in the input register moves on once the result side is free.
    assign advance  = in_valid_reg && buf_free;
    assign in_ready = !in_valid_reg || buf_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            eos_reg     <= end_of_stream;
        end
    end

    sbcp_encoder u_encoder (
        .in_byte       (in_byte_reg),
        .end_of_stream (eos_reg),
        .mode          (mode_reg),
        .enc           (enc)
    );

    sbcp_packer u_packer (
        .enc            (enc),
        .end_of_stream  (eos_reg),
        .pend_bits      (pend_bits_reg),
        .pend_cnt       (pend_cnt_reg),
        .bundle         (bundle),
        .pend_bits_next (pend_bits_next),
        .pend_cnt_next  (pend_cnt_next)
    );

    // Case mode and partial byte advance with each item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            pend_bits_reg <= 8'd0;
            pend_cnt_reg  <= 3'd0;
        end
        else if (advance)
        begin
            mode_reg      <= eos_reg ? 1'b0 : enc.mode_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    sbcp_out_buffer u_out_buffer (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .bundle       (bundle),
        .free         (buf_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .padded_final (padded_final)
    );

    // Bits of the partial byte below the pending count stay zero.
    a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ((pend_bits_reg << pend_cnt_reg) == 8'd0))
        else $error("stray bits in partial byte");

    // An end item returns the case mode and partial byte to reset.
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && eos_reg) |=> (pend_cnt_reg == 3'd0) && !mode_reg)
        else $error("end item left state behind");

    // A padded byte is always the last one of its item.
    a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && padded_final) |-> last_of_run)
        else $error("padded byte not last of its item");

endmodule

// ===== sim/tb_six_bit_charset_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_six_bit_charset_bit_packer_unit
// Self-checking bench for the six-bit character set bit packer. A directed
// run covers the ends of the byte range, every class of character, the case
// shift in both directions and both end-of-stream shapes. A random run of
// text-like streams, mostly closed by an end item, follows. A scoreboard
// class predicts every packed byte and checks each one on the result port,
// while the sender works in bursts and the receiver stalls in several patterns.
// ----------------------------------------------------------------------------
module tb_six_bit_charset_bit_packer_unit;

    import sbcp_pkg::*;

    // Expected bytes, predicted in the order the block must release them.
    class packer_scoreboard;

        typedef struct {
            logic [7:0] data;
            logic       last;
            logic       padded;
        } packed_byte_t;

        packed_byte_t expected_q[$];
        packed_byte_t run_q[$];
        bit           lower_mode;
        logic [7:0]   part_bits;
        int unsigned  part_count;
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  pads;
        int unsigned  items;
        int unsigned  ends;

        function new();
            lower_mode = 1'b0;
            part_bits  = 8'd0;
            part_count = 0;
            errors     = 0;
            checked    = 0;
            pads       = 0;
            items      = 0;
            ends       = 0;
        endfunction

        // Append a code to the partial byte, releasing every byte that fills.
        function void append_bits(logic [18:0] value, int unsigned nbits);
            packed_byte_t entry;
            for (int i = nbits - 1; i >= 0; i--)
            begin
                part_bits[7 - part_count] = value[i];
                part_count++;
                if (part_count == 8)
                begin
                    entry.data   = part_bits;
                    entry.last   = 1'b0;
                    entry.padded = 1'b0;
                    run_q.push_back(entry);
                    part_bits  = 8'd0;
                    part_count = 0;
                end
            end
        endfunction

        function bit in_charset(logic [7:0] b);
            return (b >= ChrTab && b <= ChrCr) || b == ChrSpace ||
                   (b >= ChrOpen && b <= ChrClose && b != ChrAt) ||
                   b == ChrEsc || b == ChrDel ||
                   (b >= ChrLowerA && b <= ChrLowerZ);
        endfunction

        // Work out the bytes that one accepted item releases.
        function void note_item(logic [7:0] b, logic eos);
            logic [7:0]   c;
            logic [5:0]   code;
            packed_byte_t entry;
            run_q.delete();
            items++;
            c = b;
            if (eos)
            begin
                ends++;
                append_bits(19'(CodeEscape), 6);
                append_bits(19'(CodeEnd), 7);
                if (part_count != 0)
                begin
                    entry.data   = part_bits;
                    entry.last   = 1'b0;
                    entry.padded = 1'b1;
                    run_q.push_back(entry);
                end
                lower_mode = 1'b0;
                part_bits  = 8'd0;
                part_count = 0;
            end
            else if (in_charset(c))
            begin
                // Letters may need the shift pair before their code.
                if (c >= ChrUpperA && c <= ChrUpperZ)
                begin
                    if (lower_mode)
                    begin
                        lower_mode = 1'b0;
                        append_bits(19'(CodeEscape), 6);
                        append_bits(19'(CodeShift), 7);
                    end
                end
                else if (c >= ChrLowerA && c <= ChrLowerZ)
                begin
                    c = c - 8'd32;
                    if (!lower_mode)
                    begin
                        lower_mode = 1'b1;
                        append_bits(19'(CodeEscape), 6);
                        append_bits(19'(CodeShift), 7);
                    end
                end
                if (c >= ChrOpen && c <= ChrClose && c != ChrAt)
                    code = 6'(c - 8'd32);
                else if (c == ChrSpace)
                    code = 6'd0;
                else if (c >= ChrTab && c <= ChrCr)
                    code = 6'(c - 8'd8);
                else if (c == ChrEsc)
                    code = CodeEscChr;
                else
                    code = CodeDelChr;
                append_bits(19'(code), 6);
            end
            else
            begin
                // Outside the set: escape code and the low seven bits.
                append_bits(19'(CodeEscape), 6);
                append_bits(19'(c[6:0]), 7);
            end
            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[k])
                expected_q.push_back(run_q[k]);
        endfunction

        // Compare one accepted result with the oldest expected byte.
        function void check_result(logic [7:0] data, logic last, logic padded);
            packed_byte_t entry;
            if (expected_q.size() == 0)
            begin
                $error("unexpected packed byte: out_byte 0x%02h", data);
                errors++;
                return;
            end
            entry = expected_q.pop_front();
            checked++;
            if (padded && entry.padded)
                pads++;
            if (data !== entry.data)
            begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", entry.data, data);
                errors++;
            end
            if (last !== entry.last)
            begin
                $error("last_of_run: expected %0b, actual %0b", entry.last, last);
                errors++;
            end
            if (padded !== entry.padded)
            begin
                $error("padded_final: expected %0b, actual %0b", entry.padded, padded);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

    endclass

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RxOpen,
        RxCoin,
        RxSparse,
        RxBlocky
    } rx_pattern_t;

    localparam logic [8:0] EndItem = 9'h100;
    localparam int unsigned RandomItems = 125;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'd0;
    logic       end_of_stream = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       padded_final;

    packer_scoreboard book = new();

    rx_pattern_t rx_pattern = RxOpen;
    int unsigned rx_left    = 0;
    int unsigned burst_left = 0;

    six_bit_charset_bit_packer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .padded_final  (padded_final)
    );

    always #5 clk = ~clk;

    // Result side: check accepted bytes and stall on a changing pattern.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_result(out_byte, last_of_run, padded_final);
        if (rx_left == 0)
        begin
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
            rx_left    <= $urandom_range(16, 96);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_pattern)
            RxOpen:   out_ready <= 1'b1;
            RxCoin:   out_ready <= 1'($urandom_range(0, 1));
            RxSparse: out_ready <= ($urandom_range(0, 3) == 0);
            default:  out_ready <= (rx_left[3:2] != 2'd0);
        endcase
    end

    // Hold one item on the input until it is accepted.
    task automatic send_item(input logic [7:0] b, input logic eos);
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.note_item(b, eos);
    endtask

    // Send in bursts of random length with random gaps between them.
    task automatic offer_item(input logic [7:0] b, input logic eos);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_item(b, eos);
    endtask

    // Text-like byte: mostly letters of both cases, some other set members
    // and some bytes outside the set.
    function automatic logic [7:0] pick_byte();
        logic [7:0]  b;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            b = 8'($urandom_range(ChrUpperA, ChrUpperZ));
        else if (sel <= 6)
            b = 8'($urandom_range(ChrLowerA, ChrLowerZ));
        else if (sel == 7)
        begin
            case ($urandom_range(0, 4))
                0:       b = ChrSpace;
                1:       b = 8'($urandom_range(ChrTab, ChrCr));
                2:       b = ChrEsc;
                3:       b = ChrDel;
                default: b = 8'($urandom_range(ChrOpen, ChrClose));
            endcase
        end
        else if (sel == 8)
            b = 8'($urandom_range(0, 255));
        else
            b = 8'($urandom_range(128, 255));
        return b;
    endfunction

    // Directed items: out-of-set bytes that leave seven bits pending, a
    // shift that releases three bytes, every set class and its neighbours,
    // two end items, and an end marker that exactly fills a byte.
    logic [8:0] directed_items [25] = '{
        9'd0, 9'd255, 9'd128, 9'd97, 9'd122, 9'd65, 9'd90, 9'd32, 9'd9,
        9'd15, 9'd27, 9'd127, 9'd40, 9'd93, 9'd64, 9'd8, 9'd16, 9'd94,
        9'd96, 9'd123, EndItem | 9'd255, EndItem, 9'd65, 9'd0, EndItem | 9'd170
    };

    // Stimulus and end of run.
    initial
    begin
        int unsigned rand_sent;
        int unsigned run_len;
        rand_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_items[i])
            offer_item(directed_items[i][7:0], directed_items[i][8]);

        // Random streams; a few are left open to run into the next one.
        while (rand_sent < RandomItems)
        begin
            run_len = $urandom_range(1, 16);
            repeat (run_len)
            begin
                offer_item(pick_byte(), 1'b0);
                rand_sent++;
            end
            if ($urandom_range(0, 7) != 0)
            begin
                offer_item(8'($urandom_range(0, 255)), 1'b1);
                rand_sent++;
            end
        end
        in_valid <= 1'b0;

        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d items, %0d of them end items; %0d packed bytes checked,",
                 book.items, book.ends, book.checked);
        $display("%0d of them padded flush bytes.", book.pads);
        if (book.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #500000;
        $error("timeout with %0d packed bytes still expected", book.outstanding());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
